// ===== hw/rtl/btlpm_pkg.sv =====
// Shared constants for the binary trie longest-prefix-match block.
// Field widths, opcodes, status codes and parameter defaults.
// No dependencies.
package btlpm_pkg;

	// parameter defaults
	localparam int ADDR_BITS_DEF   = 32;
	localparam int NODE_COUNT_DEF  = 1024;
	localparam int ROUTER_BITS_DEF = 16;

	// fixed field widths
	localparam int LEN_W    = 6;
	localparam int RID_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OUT_W    = 24;

	// op field
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// status field
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

endpackage

// ===== hw/rtl/binary_trie_longest_prefix_match.sv =====
// Binary trie longest-prefix-match routing table, top level.
// Depends on btlpm_pkg (widths, opcodes, status codes, defaults).
//
// Usage:
//  s_axis carries one command per transaction: an insert writes a prefix route
//  (prefix bits, length, router number), a lookup walks an address and
//  returns the router of the deepest route end on its path.
//  m_axis carries exactly one result per command: status, router, length.
//  The address sits in a shift register and is consumed one bit per cycle,
//  MSB first; each level costs one node memory access, and a walk descends
//  at most walk_len levels (walk_len is prefix_len saturated to ADDR_BITS).
//  The node memory read port sets this pace of one level per cycle.
//  One command is in flight at a time; s_axis_tready is high only while the
//  walker is idle, so the next command is taken once the walker is back in
//  idle, which it enters as the result register loads.
//  The result sits in an output register, so the next
//  command is taken while a result waits; if m_axis_tready stays low the
//  walker parks in its done state until the output register frees.
//  Reset clears the root node, the pool counter (one node, the root) and all
//  control state; node memory entries are written before they are ever read.
//  A full pool on insert reports status full and leaves no route marked.
module binary_trie_longest_prefix_match #(
	parameter int ADDR_BITS   = btlpm_pkg::ADDR_BITS_DEF,
	parameter int NODE_COUNT  = btlpm_pkg::NODE_COUNT_DEF,
	parameter int ROUTER_BITS = btlpm_pkg::ROUTER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// op, addr_bits, prefix_len, router_id (low to high), zero padded
	input  logic [((1 + ADDR_BITS + btlpm_pkg::LEN_W + btlpm_pkg::RID_W + 7) / 8) * 8 - 1:0]
		s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status, match_router, match_len (low to high)
	output logic [btlpm_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int LEN_W  = btlpm_pkg::LEN_W;
	localparam int RID_W  = btlpm_pkg::RID_W;
	localparam int RW     = ROUTER_BITS;
	localparam int IDXW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int UW     = $clog2(NODE_COUNT + 1);
	localparam int LW     = $clog2(ADDR_BITS + 1);
	localparam int NODE_W = 2 * IDXW + 1 + RW;
	// node word layout: router | route end | child 0 | child 1
	localparam int END_B  = RW;
	localparam int C0_LO  = RW + 1;
	localparam int C1_LO  = RW + 1 + IDXW;
	localparam int PLEN_LO = 1 + ADDR_BITS;
	localparam int RID_LO  = 1 + ADDR_BITS + LEN_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	// input fields
	logic                 in_op;
	logic [ADDR_BITS-1:0] in_addr;
	logic [LEN_W-1:0]     in_plen;
	logic [RID_W-1:0]     in_rid;

	assign in_op   = s_axis_tdata[0];
	assign in_addr = s_axis_tdata[1 +: ADDR_BITS];
	assign in_plen = s_axis_tdata[PLEN_LO +: LEN_W];
	assign in_rid  = s_axis_tdata[RID_LO +: RID_W];

	// control and walk registers
	logic [1:0]           state_q;
	logic                 op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [LW-1:0]        lvl_q;
	logic [LW-1:0]        len_q;
	logic [RW-1:0]        rt_in_q;
	logic [IDXW-1:0]      cur_q;
	logic [NODE_W-1:0]    node_q;
	logic                 from_mem_q;
	logic [UW-1:0]        used_q;
	logic                 found_q;
	logic [RW-1:0]        mrt_q;
	logic [LW-1:0]        mlen_q;
	logic                 full_q;

	// root node lives in flops so reset empties it
	logic [NODE_W-1:0] root_q;

	// node memory, entry 0 unused (root is in flops)
	logic [NODE_W-1:0] mem_q [NODE_COUNT];
	logic [NODE_W-1:0] rd_q;

	// output register
	logic                          out_valid_q;
	logic [btlpm_pkg::OUT_W-1:0]   out_data_q;

	// walk datapath
	logic [NODE_W-1:0] cur_word;
	logic              bit_b;
	logic [IDXW-1:0]   nxt;
	logic              at_end;
	logic              pool_full;
	logic              wr_en;
	logic [NODE_W-1:0] wr_word;
	logic              rd_en;
	logic              descend;
	logic              alloc;
	logic              finish;
	logic [LW-1:0]     len_sat;

	assign cur_word  = from_mem_q ? rd_q : node_q;
	assign bit_b     = addr_q[ADDR_BITS-1];
	assign nxt       = bit_b ? cur_word[C1_LO +: IDXW] : cur_word[C0_LO +: IDXW];
	assign at_end    = (lvl_q == len_q);
	assign pool_full = (used_q == UW'(NODE_COUNT));
	assign len_sat   = (32'(in_plen) > 32'(ADDR_BITS)) ? LW'(ADDR_BITS) : LW'(in_plen);

	always_comb begin
		wr_en   = 1'b0;
		wr_word = cur_word;
		rd_en   = 1'b0;
		descend = 1'b0;
		alloc   = 1'b0;
		finish  = 1'b0;
		if (state_q == S_WALK) begin
			priority if (at_end) begin
				finish = 1'b1;
				if (op_q == btlpm_pkg::OP_INSERT) begin
					wr_en                = 1'b1;
					wr_word[END_B]       = 1'b1;
					wr_word[0 +: RW]     = rt_in_q;
				end
			end else if (nxt != '0) begin
				rd_en   = 1'b1;
				descend = 1'b1;
			end else if (op_q == btlpm_pkg::OP_LOOKUP) begin
				finish = 1'b1;
			end else if (pool_full) begin
				// write the current node back unchanged, so a freshly allocated (empty) node is kept in the store
				finish = 1'b1;
				wr_en  = 1'b1;
			end else begin
				alloc = 1'b1;
				wr_en = 1'b1;
				if (bit_b) begin
					wr_word[C1_LO +: IDXW] = IDXW'(used_q);
				end else begin
					wr_word[C0_LO +: IDXW] = IDXW'(used_q);
				end
			end
		end
	end

	// node memory, one write and one read per cycle
	always_ff @(posedge clk) begin
		if (wr_en && cur_q != '0) begin
			mem_q[cur_q] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem_q[nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (wr_en && cur_q == '0) begin
			root_q <= wr_word;
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= UW'(1);
			from_mem_q <= 1'b0;
			found_q    <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q    <= S_WALK;
						from_mem_q <= 1'b0;
						found_q    <= 1'b0;
						full_q     <= 1'b0;
					end
				end
				S_WALK: begin
					if (finish) begin
						state_q <= S_DONE;
						if (op_q == btlpm_pkg::OP_INSERT && !at_end) begin
							full_q <= 1'b1;
						end
					end
					if (descend) begin
						from_mem_q <= 1'b1;
					end else if (alloc) begin
						from_mem_q <= 1'b0;
						used_q     <= used_q + UW'(1);
					end
					// deepest route end passed so far
					if (op_q == btlpm_pkg::OP_LOOKUP && cur_word[END_B]) begin
						found_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			op_q    <= in_op;
			addr_q  <= in_addr;
			len_q   <= len_sat;
			lvl_q   <= '0;
			rt_in_q <= RW'(32'(in_rid));
			cur_q   <= '0;
			node_q  <= root_q;
		end else if (state_q == S_WALK) begin
			if (op_q == btlpm_pkg::OP_LOOKUP && cur_word[END_B]) begin
				mrt_q  <= cur_word[0 +: RW];
				mlen_q <= lvl_q;
			end
			if (descend || alloc) begin
				addr_q <= addr_q << 1;
				lvl_q  <= lvl_q + LW'(1);
			end
			if (descend) begin
				cur_q <= nxt;
			end else if (alloc) begin
				cur_q  <= IDXW'(used_q);
				node_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
			priority if (full_q) begin
				out_data_q <= {LEN_W'(0), 16'(0), btlpm_pkg::ST_FULL};
			end else if (op_q == btlpm_pkg::OP_INSERT) begin
				out_data_q <= {LEN_W'(0), 16'(0), btlpm_pkg::ST_OK};
			end else if (found_q) begin
				out_data_q <= {LEN_W'(mlen_q), 16'(32'(mrt_q)), btlpm_pkg::ST_OK};
			end else begin
				out_data_q <= {LEN_W'(0), 16'(0), btlpm_pkg::ST_NO_MATCH};
			end
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
	// pool counter stays within the root and the pool size
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= UW'(1) && used_q <= UW'(NODE_COUNT))
		else $error("node pool counter out of range");

	// the walker never descends to the root index
	a_no_root_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> nxt != '0)
		else $error("memory read of root index");

	// depth never passes the walk length
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> lvl_q <= len_q)
		else $error("walk depth beyond walk length");
`endif

endmodule
